>>> sv/ipv4_dotted_decimal_parser_top_macros.svh
// Assertion macros for the IPv4 dotted-decimal parser checker.
// Depends on nothing; included by the checker file only.
`ifndef IPV4_DOTTED_DECIMAL_PARSER_TOP_MACROS_SVH
`define IPV4_DOTTED_DECIMAL_PARSER_TOP_MACROS_SVH

// Property checked on every rising edge outside reset.
`define IPV4DP_ASSERT(lbl, clk, rstn, expr, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) expr) else $error(msg);

// Property checked on every rising edge, reset included.
`define IPV4DP_ASSERT_ALWAYS(lbl, clk, expr, msg) \
  lbl: assert property (@(posedge clk) expr) else $error(msg);

`endif

>>> sv/ipv4dp_pkg.sv
// Shared constants, types and helpers for the IPv4 dotted-decimal parser.
// Depends on nothing; imported by the top level and its checker.
package ipv4dp_pkg;

  localparam logic [3:0] MAX_CHARS = 4'd15;
  localparam logic [2:0] FIELDS    = 3'd4;

  localparam logic [7:0] CH_ZERO = 8'h30;
  localparam logic [7:0] CH_NINE = 8'h39;
  localparam logic [7:0] CH_DOT  = 8'h2E;

  typedef enum logic [1:0] {
    REASON_OTHER      = 2'd0,
    REASON_LENGTH     = 2'd1,
    REASON_FOURTH_DOT = 2'd2,
    REASON_LAST_FLAG  = 2'd3
  } reason_t;

  // Places a field value at bit 8*idx; bits above the word are dropped.
  function automatic logic [31:0] place_field(input logic [9:0] acc, input logic [1:0] idx);
    logic [31:0] wide;
    wide = {22'd0, acc};
    return wide << {idx, 3'b000};
  endfunction

endpackage

>>> sv/ipv4_dotted_decimal_parser_top.sv
// Top level of the IPv4 dotted-decimal parser.
// Depends on ipv4dp_pkg.
//
// One ASCII character is taken per beat and a full 32-bit address word, with
// the reason parsing stopped, is returned as one result beat per string. The
// block accepts a character every cycle unless a character that ends a string
// waits on the result channel; each character passes an input register and
// then parse logic (a multiply by ten on the field value and a single 32-bit
// add of the closed field into the sum word) before the result register.
// Characters that give no result never wait on the result channel; only a
// character that ends a string stalls while an older result has not been
// taken.
module ipv4_dotted_decimal_parser_top
  import ipv4dp_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [7:0]  in_ch,
  input  logic        in_last,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [31:0] out_addr_value,
  output logic [1:0]  out_end_reason
);

  logic        s1_valid_r;
  logic [7:0]  s1_ch_r;
  logic        s1_last_r;

  logic [9:0]  acc_r, acc_nxt;
  logic [1:0]  dcnt_r, dcnt_nxt;
  logic [2:0]  fidx_r, fidx_nxt;
  logic [3:0]  ccnt_r, ccnt_nxt;
  logic [31:0] sum_r, sum_nxt;
  logic        skip_r, skip_nxt;

  logic        out_valid_r;
  logic [31:0] out_addr_r;
  reason_t     out_reason_r;

  logic        is_digit, is_dot;
  logic [9:0]  acc_step;
  logic [9:0]  acc_new;
  logic [1:0]  dcnt_new;
  logic [2:0]  fidx_new;
  logic [3:0]  ccnt_new;
  logic        has_reason;
  reason_t     reason;
  logic [31:0] addend;
  logic [31:0] sum_fin;
  logic        res_fire;
  logic        adv;

  assign is_digit = (s1_ch_r >= CH_ZERO) && (s1_ch_r <= CH_NINE);
  assign is_dot   = (s1_ch_r == CH_DOT);

  // acc * 10 + digit, kept to ten bits; the digit is the low nibble of an
  // ASCII numeral.
  assign acc_step = {acc_r[6:0], 3'b000} + {acc_r[8:0], 1'b0} + {6'd0, s1_ch_r[3:0]};

  always_comb begin
    acc_new    = acc_r;
    dcnt_new   = dcnt_r;
    fidx_new   = fidx_r;
    ccnt_new   = ccnt_r;
    has_reason = 1'b0;
    reason     = REASON_OTHER;
    if (is_digit) begin
      if (dcnt_r != 2'd3) begin
        acc_new  = acc_step;
        dcnt_new = dcnt_r + 2'd1;
      end
      ccnt_new = ccnt_r + 4'd1;
    end else if (is_dot) begin
      acc_new  = '0;
      dcnt_new = '0;
      fidx_new = fidx_r + 3'd1;
      ccnt_new = ccnt_r + 4'd1;
      if (fidx_new >= FIELDS) begin
        has_reason = 1'b1;
        reason     = REASON_FOURTH_DOT;
      end
    end else begin
      has_reason = 1'b1;
      reason     = REASON_OTHER;
    end
    if (!has_reason && (ccnt_new >= MAX_CHARS)) begin
      has_reason = 1'b1;
      reason     = REASON_LENGTH;
    end
    if (!has_reason && s1_last_r) begin
      has_reason = 1'b1;
      reason     = REASON_LAST_FLAG;
    end
  end

  // Only one field can close per character: the open field on a dot, or the
  // field left open when the string ends on anything else.
  always_comb begin
    addend = '0;
    if (is_dot) begin
      if ((dcnt_r != 2'd0) && (fidx_r < FIELDS)) begin
        addend = place_field(acc_r, fidx_r[1:0]);
      end
    end else if (has_reason && (dcnt_new != 2'd0) && (fidx_r < FIELDS)) begin
      addend = place_field(acc_new, fidx_r[1:0]);
    end
  end

  assign sum_fin  = sum_r + addend;
  assign res_fire = s1_valid_r && !skip_r && has_reason;
  assign adv      = s1_valid_r && (!res_fire || !out_valid_r || out_ready);
  assign in_ready = !s1_valid_r || adv;

  always_comb begin
    acc_nxt  = acc_r;
    dcnt_nxt = dcnt_r;
    fidx_nxt = fidx_r;
    ccnt_nxt = ccnt_r;
    sum_nxt  = sum_r;
    skip_nxt = skip_r;
    if (adv) begin
      if (skip_r) begin
        skip_nxt = !s1_last_r;
      end else if (has_reason) begin
        acc_nxt  = '0;
        dcnt_nxt = '0;
        fidx_nxt = '0;
        ccnt_nxt = '0;
        sum_nxt  = '0;
        skip_nxt = !s1_last_r;
      end else begin
        acc_nxt  = acc_new;
        dcnt_nxt = dcnt_new;
        fidx_nxt = fidx_new;
        ccnt_nxt = ccnt_new;
        sum_nxt  = sum_fin;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      acc_r       <= '0;
      dcnt_r      <= '0;
      fidx_r      <= '0;
      ccnt_r      <= '0;
      sum_r       <= '0;
      skip_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (in_ready) begin
        s1_valid_r <= in_valid;
      end
      acc_r  <= acc_nxt;
      dcnt_r <= dcnt_nxt;
      fidx_r <= fidx_nxt;
      ccnt_r <= ccnt_nxt;
      sum_r  <= sum_nxt;
      skip_r <= skip_nxt;
      if (adv && res_fire) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      s1_ch_r   <= in_ch;
      s1_last_r <= in_last;
    end
    if (adv && res_fire) begin
      out_addr_r   <= sum_fin;
      out_reason_r <= reason;
    end
  end

  assign out_valid      = out_valid_r;
  assign out_addr_value = out_addr_r;
  assign out_end_reason = out_reason_r;

endmodule

>>> sv/ipv4dp_checker.sv
// Port-level checker for the IPv4 dotted-decimal parser, bound to the top level.
// Depends on ipv4dp_pkg and ipv4_dotted_decimal_parser_top_macros.svh.
`include "ipv4_dotted_decimal_parser_top_macros.svh"

module ipv4dp_checker
  import ipv4dp_pkg::*;
(
  input logic        clk,
  input logic        rst_n,
  input logic        in_valid,
  input logic        in_ready,
  input logic        out_valid,
  input logic        out_ready,
  input logic [31:0] out_addr_value,
  input logic [1:0]  out_end_reason
);

  // A result beat that is not taken keeps its word and reason.
  `IPV4DP_ASSERT(a_out_hold, clk, rst_n, out_valid && !out_ready |=> out_valid && $stable(out_addr_value) && $stable(out_end_reason), "result beat changed while stalled")

  // Reset empties the result register.
  `IPV4DP_ASSERT_ALWAYS(a_reset_clears, clk, !rst_n |=> !out_valid, "result valid after reset")

  // A new result always comes from a character beat taken at the input, through the input and result registers.
  `IPV4DP_ASSERT(a_latency, clk, rst_n, $rose(out_valid) |-> $past(in_valid && in_ready, 2), "result without a character beat")

  // With the result register empty, the input side never stalls.
  `IPV4DP_ASSERT(a_no_false_stall, clk, rst_n, !out_valid |-> in_ready, "input stalled with result register empty")

endmodule

bind ipv4_dotted_decimal_parser_top ipv4dp_checker u_ipv4dp_checker (.*);

>>> verif/tb_top.sv
`timescale 1ns / 1ps
// Self-checking testbench for the IPv4 dotted-decimal parser top level.
// Depends on ipv4dp_pkg and ipv4_dotted_decimal_parser_top; needs nothing else.
module tb_top
  import ipv4dp_pkg::*;
();

  typedef struct packed {
    logic [7:0]  ch;
    logic        fin;
    logic        known;
    logic [31:0] value;
    reason_t     why;
  } char_beat_t;

  typedef struct packed {
    logic [31:0] value;
    reason_t     why;
  } parsed_t;

  localparam int IDLE_PCT   = 28;
  localparam int RAND_CHARS = 450;
  localparam int HOLD_LEN   = 240;
  localparam int STALL_MAX  = 3000;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_valid = 1'b0;
  logic        in_ready;
  logic [7:0]  in_ch = 8'h00;
  logic        in_last = 1'b0;
  logic        out_valid;
  logic        out_ready = 1'b0;
  logic [31:0] out_addr_value;
  logic [1:0]  out_end_reason;

  ipv4_dotted_decimal_parser_top dut (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .in_ch          (in_ch),
    .in_last        (in_last),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .out_addr_value (out_addr_value),
    .out_end_reason (out_end_reason)
  );

  always #2 clk = ~clk;

  char_beat_t char_q [$];
  parsed_t    parsed_q [$];
  char_beat_t probe_tab [25];
  char_beat_t live;

  int chars_sent = 0;
  int words_seen = 0;
  int reason_seen [4] = '{0, 0, 0, 0};
  int mismatches = 0;
  int cyc = 0;
  int stall_cycles = 0;
  int hold_left = 0;
  bit hold_done = 1'b0;
  wire quiet = (cyc >= 150) && (cyc < 450);

  // Parser state mirrored by the predictor.
  logic [9:0]  p_acc;
  logic [1:0]  p_digits;
  logic [2:0]  p_field;
  logic [3:0]  p_chars;
  logic [31:0] p_sum;
  logic        p_skip;

  bit          pred_got;
  parsed_t     pred_res;
  parsed_t     want_res;

  task automatic close_field();
    logic [31:0] wide;
    wide = {22'd0, p_acc};
    if (p_digits != 0 && p_field < FIELDS) p_sum = p_sum + (wide << (p_field * 8));
    p_acc = '0;
    p_digits = '0;
  endtask

  task automatic parse_char(input logic [7:0] ch, input logic fin, output bit got,
                            output parsed_t res);
    logic [31:0] grown;
    bit          stop;
    reason_t     why;
    got = 1'b0;
    res = '0;
    stop = 1'b0;
    why = REASON_OTHER;
    if (p_skip) begin
      if (fin) p_skip = 1'b0;
      return;
    end
    if (ch >= CH_ZERO && ch <= CH_NINE) begin
      if (p_digits < 3) begin
        grown = p_acc * 10 + (ch - CH_ZERO);
        p_acc = grown[9:0];
        p_digits = p_digits + 1'b1;
      end
      p_chars = p_chars + 1'b1;
    end else if (ch == CH_DOT) begin
      close_field();
      p_field = p_field + 1'b1;
      p_chars = p_chars + 1'b1;
      if (p_field >= FIELDS) begin
        stop = 1'b1;
        why = REASON_FOURTH_DOT;
      end
    end else begin
      stop = 1'b1;
      why = REASON_OTHER;
    end
    if (!stop && p_chars >= MAX_CHARS) begin
      stop = 1'b1;
      why = REASON_LENGTH;
    end
    if (!stop && fin) begin
      stop = 1'b1;
      why = REASON_LAST_FLAG;
    end
    if (!stop) return;
    close_field();
    got = 1'b1;
    res.value = p_sum;
    res.why = why;
    p_skip = !fin;
    p_field = '0;
    p_chars = '0;
    p_sum = '0;
  endtask

  function automatic logic [7:0] pick_digit();
    return CH_ZERO + 8'($urandom_range(0, 9));
  endfunction

  function automatic logic [7:0] pick_other();
    logic [7:0] b;
    do b = 8'($urandom_range(0, 255));
    while ((b >= CH_ZERO && b <= CH_NINE) || b == CH_DOT);
    return b;
  endfunction

  task automatic queue_char(input logic [7:0] ch, input logic fin);
    char_beat_t c;
    c = '0;
    c.ch = ch;
    c.fin = fin;
    char_q.push_back(c);
  endtask

  // Most strings are four dot-separated fields, some empty or over-long; the rest are early stops,
  // dot runs, over-long strings and raw noise that may not even carry a last flag.
  task automatic compose_address();
    logic [7:0] txt [$];
    int kind, n, f;
    bit closes;
    kind = $urandom_range(0, 99);
    closes = 1'b1;
    if (kind < 55) begin
      for (f = 0; f < 4; f++) begin
        n = $urandom_range(0, 9);
        n = (n == 0) ? 0 : (n < 8) ? $urandom_range(1, 3) : $urandom_range(4, 5);
        repeat (n) txt.push_back(pick_digit());
        if (f < 3) txt.push_back(CH_DOT);
      end
      n = $urandom_range(0, 9);
      if (n < 2) txt.push_back(pick_other());
      else if (n == 2) txt.push_back(CH_DOT);
      if (n < 3) repeat ($urandom_range(0, 3)) txt.push_back(8'($urandom_range(0, 255)));
    end else if (kind < 70) begin
      repeat ($urandom_range(0, 6))
        txt.push_back(($urandom_range(0, 3) == 0) ? CH_DOT : pick_digit());
      txt.push_back(pick_other());
      repeat ($urandom_range(0, 3)) txt.push_back(8'($urandom_range(0, 255)));
    end else if (kind < 80) begin
      repeat ($urandom_range(1, 8))
        txt.push_back(($urandom_range(0, 1) == 0) ? CH_DOT : pick_digit());
    end else if (kind < 90) begin
      repeat ($urandom_range(14, 20))
        txt.push_back(($urandom_range(0, 7) == 0) ? CH_DOT : pick_digit());
    end else begin
      repeat ($urandom_range(1, 6)) txt.push_back(8'($urandom_range(0, 255)));
      closes = 1'($urandom_range(0, 1));
    end
    foreach (txt[i]) queue_char(txt[i], closes && (i == txt.size() - 1));
  endtask

  task automatic flag_failure(input string what, input parsed_t want);
    mismatches++;
    if (mismatches <= 10)
      $display("[%0t] %s: expected value %08h reason %0d, got value %08h reason %0d",
               $realtime, what, want.value, want.why, out_addr_value, out_end_reason);
  endtask

  // Sender: one character beat at a time, with random gaps outside the quiet window.
  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && in_ready) begin
        parse_char(live.ch, live.fin, pred_got, pred_res);
        if (live.known) parsed_q.push_back({live.value, live.why});
        else if (pred_got) parsed_q.push_back(pred_res);
        chars_sent <= chars_sent + 1;
      end
      if (!in_valid || in_ready) begin
        if (char_q.size() > 0 && (quiet || $urandom_range(0, 99) >= IDLE_PCT)) begin
          live = char_q.pop_front();
          in_valid <= 1'b1;
          in_ch <= live.ch;
          in_last <= live.fin;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // Receiver: checks each result beat and, once, holds off long enough to fill the block.
  always @(posedge clk) begin
    if (!rst_n) begin
      out_ready <= 1'b0;
    end else begin
      if (out_valid && out_ready) begin
        words_seen <= words_seen + 1;
        reason_seen[out_end_reason] <= reason_seen[out_end_reason] + 1;
        if (parsed_q.size() == 0) begin
          flag_failure("unexpected result", '0);
        end else begin
          want_res = parsed_q.pop_front();
          if (out_addr_value !== want_res.value || out_end_reason !== want_res.why)
            flag_failure("result mismatch", want_res);
        end
      end
      if (hold_left > 0) begin
        hold_left <= hold_left - 1;
        out_ready <= 1'b0;
      end else if (!hold_done && chars_sent >= 330) begin
        hold_left <= HOLD_LEN;
        hold_done <= 1'b1;
        out_ready <= 1'b0;
      end else begin
        out_ready <= quiet || ($urandom_range(0, 99) >= IDLE_PCT);
      end
    end
  end

  always @(posedge clk) begin
    cyc <= cyc + 1;
    if ((in_valid && in_ready) || (out_valid && out_ready)) stall_cycles <= 0;
    else stall_cycles <= stall_cycles + 1;
    if (stall_cycles >= STALL_MAX) begin
      $display("Timeout after %0d cycles without a beat", stall_cycles);
      $display("Some tests failed");
      $finish;
    end
  end

  initial begin
    // Rows with a typed result are checked against it; the others against the predictor.
    probe_tab = '{
      '{8'h30, 1'b1, 1'b1, 32'h0000_0000, REASON_LAST_FLAG},
      '{8'h00, 1'b0, 1'b1, 32'h0000_0000, REASON_OTHER},
      '{8'hFF, 1'b1, 1'b0, 32'h0, REASON_OTHER},
      '{CH_DOT, 1'b0, 1'b0, 32'h0, REASON_OTHER},
      '{CH_DOT, 1'b0, 1'b0, 32'h0, REASON_OTHER},
      '{CH_DOT, 1'b0, 1'b0, 32'h0, REASON_OTHER},
      '{CH_DOT, 1'b0, 1'b1, 32'h0000_0000, REASON_FOURTH_DOT},
      '{8'h31, 1'b1, 1'b0, 32'h0, REASON_OTHER},
      '{8'h2F, 1'b1, 1'b1, 32'h0000_0000, REASON_OTHER},
      '{8'h3A, 1'b1, 1'b1, 32'h0000_0000, REASON_OTHER},
      '{8'h32, 1'b0, 1'b0, 32'h0, REASON_OTHER},
      '{8'h35, 1'b0, 1'b0, 32'h0, REASON_OTHER},
      '{8'h35, 1'b0, 1'b0, 32'h0, REASON_OTHER},
      '{CH_DOT, 1'b0, 1'b0, 32'h0, REASON_OTHER},
      '{8'h32, 1'b0, 1'b0, 32'h0, REASON_OTHER},
      '{8'h35, 1'b0, 1'b0, 32'h0, REASON_OTHER},
      '{8'h35, 1'b0, 1'b0, 32'h0, REASON_OTHER},
      '{CH_DOT, 1'b0, 1'b0, 32'h0, REASON_OTHER},
      '{8'h32, 1'b0, 1'b0, 32'h0, REASON_OTHER},
      '{8'h35, 1'b0, 1'b0, 32'h0, REASON_OTHER},
      '{8'h35, 1'b0, 1'b0, 32'h0, REASON_OTHER},
      '{CH_DOT, 1'b0, 1'b0, 32'h0, REASON_OTHER},
      '{8'h32, 1'b0, 1'b0, 32'h0, REASON_OTHER},
      '{8'h35, 1'b0, 1'b0, 32'h0, REASON_OTHER},
      // Length limit and last flag together: the length limit wins.
      '{8'h35, 1'b1, 1'b1, 32'hFFFF_FFFF, REASON_LENGTH}
    };
    foreach (probe_tab[i]) char_q.push_back(probe_tab[i]);
    while (char_q.size() < $size(probe_tab) + RAND_CHARS) compose_address();

    p_acc = '0;
    p_digits = '0;
    p_field = '0;
    p_chars = '0;
    p_sum = '0;
    p_skip = 1'b0;

    repeat (7) @(posedge clk);
    rst_n <= 1'b1;

    while (char_q.size() > 0 || in_valid) @(posedge clk);
    while (parsed_q.size() > 0) @(posedge clk);
    repeat (12) @(posedge clk);

    $display("Sent %0d characters and checked %0d address words", chars_sent, words_seen);
    $display("End reasons seen: other %0d, length %0d, fourth dot %0d, last flag %0d",
             reason_seen[0], reason_seen[1], reason_seen[2], reason_seen[3]);
    if (mismatches == 0) begin
      $display("All tests passed");
    end else begin
      $display("%0d mismatches in total", mismatches);
      $display("Some tests failed");
    end
    $finish;
  end

endmodule
